// File: rtl/core/bss_pkg.sv
// Shared widths, constants and transfer types for bandwidth sample statistics.
package bss_pkg;

   localparam int TS_W     = 48;
   localparam int BW_W     = 32;
   localparam int REL_W    = 49;
   localparam int TOTAL_W  = 48;
   localparam int COUNT_W  = 32;

   // 100 percent in Q24.8
   localparam int PERCENT_SCALE = 25600;

   typedef struct packed {
      logic signed [REL_W-1:0] relative_time;
      logic [BW_W-1:0]         bandwidth;
      logic [BW_W-1:0]         difference;
      logic [BW_W-1:0]         previous;
      logic                    first;
      logic [TOTAL_W-1:0]      difference_total;
      logic [COUNT_W-1:0]      count;
   } job_type;

   typedef struct packed {
      logic signed [REL_W-1:0] relative_time;
      logic [BW_W-1:0]         sample_echo;
      logic [BW_W-1:0]         window_mean;
      logic [BW_W-1:0]         step_difference;
      logic [BW_W-1:0]         step_percent;
      logic                    percent_invalid;
      logic [BW_W-1:0]         mean_difference;
      logic [TOTAL_W-1:0]      difference_total;
   } result_type;

endpackage

// File: rtl/core/bss_queue.sv
// Small register queue with push/full and pop/empty sides.
module bss_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[head_ff];

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (do_push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (do_pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/bss_divider.sv
// Restoring divider, one quotient bit per cycle.
module bss_divider #(
   parameter int N_W = 48,
   parameter int D_W = 32,
   localparam int CNT_W = $clog2(N_W + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic [N_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [D_W-1:0]   rem_ff, rem_in, den_ff, den_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W:0]     trial, reduced;
   logic             fits;

   assign trial    = {rem_ff, quo_ff[N_W-1]};
   assign reduced  = trial - {1'b0, den_ff};
   assign fits     = (trial >= {1'b0, den_ff});
   assign busy     = busy_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(N_W);
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? reduced[D_W-1:0] : trial[D_W-1:0];
         quo_in  = {quo_ff[N_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// File: rtl/core/bss_front.sv
// Front end: takes samples, keeps window and difference state, forms a job.
module bss_front #(
   parameter int WINDOW_LENGTH = 5,
   localparam int SUM_W  = 32 + $clog2(WINDOW_LENGTH),
   localparam int DIV_W  = $clog2(WINDOW_LENGTH + 1),
   localparam int SLOT_W = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [bss_pkg::TS_W-1:0]    csr_write_data,
   input  logic                        accept,
   input  logic [bss_pkg::TS_W-1:0]    timestamp,
   input  logic [bss_pkg::BW_W-1:0]    bandwidth,
   output bss_pkg::job_type            job,
   output logic [SUM_W-1:0]            window_sum,
   output logic [DIV_W-1:0]            window_divisor
);

   logic [bss_pkg::TS_W-1:0]    tmin_ff;
   logic [bss_pkg::BW_W-1:0]    win_ff [WINDOW_LENGTH];
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic [SUM_W-1:0]            wsum_ff, wsum_in;
   logic [bss_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [bss_pkg::BW_W-1:0]    prev_ff;
   logic [bss_pkg::TOTAL_W-1:0] dsum_ff, dsum_in;
   logic [bss_pkg::TOTAL_W:0]   dsum_wide;
   logic [bss_pkg::BW_W-1:0]    diff;
   logic                        first;

   assign first    = (count_ff == '0);
   assign wsum_in  = wsum_ff - SUM_W'(win_ff[slot_ff]) + SUM_W'(bandwidth);
   assign slot_in  = (slot_ff == SLOT_W'(WINDOW_LENGTH - 1)) ? '0 : slot_ff + 1'b1;
   assign count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   always_comb begin
      if (first) begin
         diff = '0;
      end else if (bandwidth >= prev_ff) begin
         diff = bandwidth - prev_ff;
      end else begin
         diff = prev_ff - bandwidth;
      end
   end

   assign dsum_wide = {1'b0, dsum_ff} + (bss_pkg::TOTAL_W + 1)'(diff);
   assign dsum_in   = dsum_wide[bss_pkg::TOTAL_W] ? '1 : dsum_wide[bss_pkg::TOTAL_W-1:0];

   always_comb begin
      if (count_in < bss_pkg::COUNT_W'(WINDOW_LENGTH)) begin
         window_divisor = DIV_W'(count_in);
      end else begin
         window_divisor = DIV_W'(WINDOW_LENGTH);
      end
   end

   assign window_sum           = wsum_in;
   assign job.relative_time    = $signed({1'b0, timestamp} - {1'b0, tmin_ff});
   assign job.bandwidth        = bandwidth;
   assign job.difference       = diff;
   assign job.previous         = prev_ff;
   assign job.first            = first;
   assign job.difference_total = dsum_in;
   assign job.count            = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmin_ff  <= '0;
         slot_ff  <= '0;
         wsum_ff  <= '0;
         count_ff <= '0;
         prev_ff  <= '0;
         dsum_ff  <= '0;
         for (int k = 0; k < WINDOW_LENGTH; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            tmin_ff <= csr_write_data;
         end
         if (accept) begin
            win_ff[slot_ff] <= bandwidth;
            slot_ff         <= slot_in;
            wsum_ff         <= wsum_in;
            count_ff        <= count_in;
            prev_ff         <= bandwidth;
            dsum_ff         <= dsum_in;
         end
      end
   end

endmodule

// File: rtl/core/bss_back.sv
// Back end: runs the three divisions of a job and builds the result.
module bss_back #(
   parameter int WINDOW_LENGTH = 5,
   localparam int SUM_W = 32 + $clog2(WINDOW_LENGTH),
   localparam int DIV_W = $clog2(WINDOW_LENGTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   output logic                job_pop,
   input  bss_pkg::job_type    job,
   input  logic [SUM_W-1:0]    window_sum,
   input  logic [DIV_W-1:0]    window_divisor,
   input  logic                result_full,
   output logic                result_push,
   output bss_pkg::result_type result
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                        state_ff, state_in;
   bss_pkg::job_type            hold_ff;
   logic [bss_pkg::TOTAL_W-1:0] pct_dividend, pct_q, mean_q;
   logic [SUM_W-1:0]            win_q;
   logic                        pct_busy, mean_busy, win_busy, all_done;

   function automatic logic [bss_pkg::BW_W-1:0] sat32(input logic [bss_pkg::TOTAL_W-1:0] v);
      sat32 = (v[bss_pkg::TOTAL_W-1:bss_pkg::BW_W] != '0) ? '1 : v[bss_pkg::BW_W-1:0];
   endfunction

   assign job_pop      = (state_ff == ST_IDLE) && !job_empty;
   assign pct_dividend = bss_pkg::TOTAL_W'(job.difference)
                       * bss_pkg::TOTAL_W'(bss_pkg::PERCENT_SCALE);
   assign all_done     = !pct_busy && !mean_busy && !win_busy;
   assign result_push  = (state_ff == ST_RUN) && all_done && !result_full;

   bss_divider #(.N_W(bss_pkg::TOTAL_W), .D_W(bss_pkg::BW_W)) u_pct_div (
      .clock    (clock),
      .reset    (reset),
      .start    (job_pop),
      .dividend (pct_dividend),
      .divisor  (job.previous),
      .busy     (pct_busy),
      .quotient (pct_q)
   );

   bss_divider #(.N_W(bss_pkg::TOTAL_W), .D_W(bss_pkg::COUNT_W)) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (job_pop),
      .dividend (job.difference_total),
      .divisor  (job.count),
      .busy     (mean_busy),
      .quotient (mean_q)
   );

   bss_divider #(.N_W(SUM_W), .D_W(DIV_W)) u_win_div (
      .clock    (clock),
      .reset    (reset),
      .start    (job_pop),
      .dividend (window_sum),
      .divisor  (window_divisor),
      .busy     (win_busy),
      .quotient (win_q)
   );

   always_comb begin
      result.relative_time    = hold_ff.relative_time;
      result.sample_echo      = hold_ff.bandwidth;
      result.window_mean      = win_q[bss_pkg::BW_W-1:0];
      result.step_difference  = hold_ff.difference;
      result.difference_total = hold_ff.difference_total;
      if (hold_ff.first) begin
         result.step_percent    = '0;
         result.percent_invalid = 1'b0;
         result.mean_difference = '0;
      end else begin
         result.mean_difference = sat32(mean_q);
         if (hold_ff.previous == '0) begin
            result.step_percent    = '1;
            result.percent_invalid = 1'b1;
         end else begin
            result.step_percent    = sat32(pct_q);
            result.percent_invalid = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (job_pop) state_in = ST_RUN;
         ST_RUN:  if (result_push) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         hold_ff <= job;
      end
   end

endmodule

// File: rtl/core/bandwidth_sample_statistics.sv
// Top level of the bandwidth sample statistics block.
//
// One transfer in (timestamp, Q24.8 bandwidth) gives one transfer out with
// the relative time, the windowed mean, the step difference and its percent,
// and the running difference total and mean. The front end updates all
// running state in the cycle a sample is pushed and hands a job to a short
// queue, so JOB_DEPTH samples can be pushed back to back. The back end takes
// one job at a time and runs three serial dividers side by side; the 48-bit
// dividend of the percent and mean-difference divisions sets the pace: a pop,
// one divide step per dividend bit, a push that waits while the result queue
// is full. Results wait in a queue of RESULT_DEPTH entries. The user must
// write the time base subtracted from every timestamp, through
// csr_write_enable/csr_write_data, only while idle; the block does not check.
module bandwidth_sample_statistics #(
   parameter int WINDOW_LENGTH = 5,
   parameter int JOB_DEPTH     = 2,
   parameter int RESULT_DEPTH  = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // input transfers
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [bss_pkg::TS_W-1:0]            req_timestamp,
   input  logic [bss_pkg::BW_W-1:0]            req_bandwidth,
   // result transfers
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [bss_pkg::REL_W-1:0]    rsp_relative_time,
   output logic [bss_pkg::BW_W-1:0]            rsp_sample_echo,
   output logic [bss_pkg::BW_W-1:0]            rsp_window_mean,
   output logic [bss_pkg::BW_W-1:0]            rsp_step_difference,
   output logic [bss_pkg::BW_W-1:0]            rsp_step_percent,
   output logic                                rsp_percent_invalid,
   output logic [bss_pkg::BW_W-1:0]            rsp_mean_difference,
   output logic [bss_pkg::TOTAL_W-1:0]         rsp_difference_total,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [bss_pkg::TS_W-1:0]            csr_write_data
);

   localparam int SUM_W   = 32 + $clog2(WINDOW_LENGTH);
   localparam int DIV_W   = $clog2(WINDOW_LENGTH + 1);
   localparam int JOB_W   = $bits(bss_pkg::job_type);
   localparam int ENTRY_W = JOB_W + SUM_W + DIV_W;
   localparam int RES_W   = $bits(bss_pkg::result_type);

   // front -> job queue
   bss_pkg::job_type     front_job;
   logic [SUM_W-1:0]     front_sum;
   logic [DIV_W-1:0]     front_div;
   logic                 accept;

   // job queue -> back
   logic [ENTRY_W-1:0]   head_entry;
   bss_pkg::job_type     back_job;
   logic [SUM_W-1:0]     back_sum;
   logic [DIV_W-1:0]     back_div;
   logic                 job_empty, job_pop;

   // back -> result queue
   bss_pkg::result_type  back_result, rsp_result;
   logic [RES_W-1:0]     rsp_bits;
   logic                 result_full, result_push;

   assign accept = req_push && !req_full;

   bss_front #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .timestamp        (req_timestamp),
      .bandwidth        (req_bandwidth),
      .job              (front_job),
      .window_sum       (front_sum),
      .window_divisor   (front_div)
   );

   bss_queue #(.WIDTH(ENTRY_W), .DEPTH(JOB_DEPTH)) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({front_job, front_sum, front_div}),
      .full      (req_full),
      .pop       (job_pop),
      .pop_data  (head_entry),
      .empty     (job_empty)
   );

   assign back_job = bss_pkg::job_type'(head_entry[ENTRY_W-1 -: JOB_W]);
   assign back_sum = head_entry[DIV_W +: SUM_W];
   assign back_div = head_entry[DIV_W-1:0];

   bss_back #(.WINDOW_LENGTH(WINDOW_LENGTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_empty      (job_empty),
      .job_pop        (job_pop),
      .job            (back_job),
      .window_sum     (back_sum),
      .window_divisor (back_div),
      .result_full    (result_full),
      .result_push    (result_push),
      .result         (back_result)
   );

   bss_queue #(.WIDTH(RES_W), .DEPTH(RESULT_DEPTH)) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp_result           = bss_pkg::result_type'(rsp_bits);
   assign rsp_relative_time    = rsp_result.relative_time;
   assign rsp_sample_echo      = rsp_result.sample_echo;
   assign rsp_window_mean      = rsp_result.window_mean;
   assign rsp_step_difference  = rsp_result.step_difference;
   assign rsp_step_percent     = rsp_result.step_percent;
   assign rsp_percent_invalid  = rsp_result.percent_invalid;
   assign rsp_mean_difference  = rsp_result.mean_difference;
   assign rsp_difference_total = rsp_result.difference_total;

endmodule

// File: rtl/core/bss_checker.sv
// Port-level checks for bandwidth sample statistics, bound to the top level.
module bss_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic signed [bss_pkg::REL_W-1:0] rsp_relative_time,
   input logic [bss_pkg::BW_W-1:0]         rsp_step_difference,
   input logic [bss_pkg::BW_W-1:0]         rsp_step_percent,
   input logic                             rsp_percent_invalid,
   input logic [bss_pkg::BW_W-1:0]         rsp_mean_difference,
   input logic [bss_pkg::TOTAL_W-1:0]      rsp_difference_total
);

   // nothing left over after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   // a waiting result holds until popped
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_relative_time) && $stable(rsp_difference_total)))
      else $error("waiting result changed before pop");

   // zero previous sample saturates the percent
   a_invalid_sat: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_percent_invalid) |-> (rsp_step_percent == '1))
      else $error("invalid percent not saturated");

   // no step, valid base: no percent
   a_zero_step: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_percent_invalid && (rsp_step_difference == '0))
         |-> (rsp_step_percent == '0))
      else $error("percent nonzero on zero step");

   // the mean of the differences never exceeds their total
   a_mean_le_total: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (bss_pkg::TOTAL_W'(rsp_mean_difference) <= rsp_difference_total))
      else $error("mean difference above difference total");

endmodule

bind bandwidth_sample_statistics bss_checker u_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bandwidth sample statistics block.
module testbench;

   // ---------------------------------------------------------------------
   // Run parameters
   // ---------------------------------------------------------------------
   localparam int WINDOW_LENGTH = 5;
   localparam int MAX_GAP       = 19;     // longest idle stretch per transfer
   localparam int HOLD_CYCLES   = 600;    // long result hold-off, fills the block
   localparam int DRAIN_CYCLES  = 100;    // quiet time after the last result
   localparam int DRAIN_LIMIT   = 5000;   // give up waiting for results after this
   localparam int REPORT_LIMIT  = 10;     // mismatches printed in full

   localparam logic [bss_pkg::TS_W-1:0] TS_MAX = '1;
   localparam logic [bss_pkg::BW_W-1:0] BW_MAX = '1;

   // ---------------------------------------------------------------------
   // Block ports; every input is known from time zero
   // ---------------------------------------------------------------------
   logic                             clock;
   logic                             reset                = 1'b1;
   logic                             req_push             = 1'b0;
   logic                             req_full;
   logic [bss_pkg::TS_W-1:0]         req_timestamp        = '0;
   logic [bss_pkg::BW_W-1:0]         req_bandwidth        = '0;
   logic                             rsp_empty;
   logic                             rsp_pop              = 1'b0;
   logic signed [bss_pkg::REL_W-1:0] rsp_relative_time;
   logic [bss_pkg::BW_W-1:0]         rsp_sample_echo;
   logic [bss_pkg::BW_W-1:0]         rsp_window_mean;
   logic [bss_pkg::BW_W-1:0]         rsp_step_difference;
   logic [bss_pkg::BW_W-1:0]         rsp_step_percent;
   logic                             rsp_percent_invalid;
   logic [bss_pkg::BW_W-1:0]         rsp_mean_difference;
   logic [bss_pkg::TOTAL_W-1:0]      rsp_difference_total;
   logic                             csr_write_enable     = 1'b0;
   logic [bss_pkg::TS_W-1:0]         csr_write_data       = '0;

   bandwidth_sample_statistics #(
      .WINDOW_LENGTH(WINDOW_LENGTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_timestamp       (req_timestamp),
      .req_bandwidth       (req_bandwidth),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_relative_time   (rsp_relative_time),
      .rsp_sample_echo     (rsp_sample_echo),
      .rsp_window_mean     (rsp_window_mean),
      .rsp_step_difference (rsp_step_difference),
      .rsp_step_percent    (rsp_step_percent),
      .rsp_percent_invalid (rsp_percent_invalid),
      .rsp_mean_difference (rsp_mean_difference),
      .rsp_difference_total(rsp_difference_total),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   // ---------------------------------------------------------------------
   // Predictor state, mirrors the block's running statistics
   // ---------------------------------------------------------------------
   logic [bss_pkg::BW_W-1:0]    window_samples [WINDOW_LENGTH] = '{default: '0};
   int                          window_slot    = 0;
   logic [bss_pkg::COUNT_W-1:0] samples_seen   = '0;
   logic [bss_pkg::BW_W-1:0]    last_sample    = '0;
   logic [63:0]                 difference_sum = '0;   // kept wide to see 48-bit saturation
   logic [bss_pkg::TS_W-1:0]    ts_minimum     = '0;

   bss_pkg::result_type expected_results [$];  // oldest expectation at the front
   int                  mismatch_count = 0;

   // Traffic shaping, set per phase by the test tasks
   bit                       send_idle       = 1'b1;
   bit                       pop_idle        = 1'b1;
   bit                       hold_request    = 1'b0;
   bit                       holding         = 1'b0;
   logic [bss_pkg::TS_W-1:0] sample_clock_us = '0;  // monotonic time base for random traffic

   // ---------------------------------------------------------------------
   // Clock and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Worst legal run is a few ms; anything past this is a hang.
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor: one sample in, one expected result out
   // ---------------------------------------------------------------------
   function automatic bss_pkg::result_type stats_step(
      input logic [bss_pkg::TS_W-1:0] ts,
      input logic [bss_pkg::BW_W-1:0] bw);
      bss_pkg::result_type r;
      logic [63:0]         window_sum;
      logic [63:0]         count_after;
      logic [63:0]         divisor;
      logic [63:0]         diff;
      logic [63:0]         quotient;
      int                  k;
      r = '0;

      // window of recent samples; mean over what has been seen during warm-up
      window_samples[window_slot] = bw;
      window_slot = (window_slot + 1 >= WINDOW_LENGTH) ? 0 : window_slot + 1;
      window_sum = '0;
      for (k = 0; k < WINDOW_LENGTH; k++)
         window_sum += 64'(window_samples[k]);
      count_after = 64'(samples_seen) + 64'd1;
      if (count_after > 64'hFFFF_FFFF)
         count_after = 64'hFFFF_FFFF;
      divisor = (count_after < WINDOW_LENGTH) ? count_after : 64'(WINDOW_LENGTH);

      r.relative_time   = {1'b0, ts} - {1'b0, ts_minimum};
      r.sample_echo     = bw;
      r.window_mean     = 32'(window_sum / divisor);

      // difference statistics start with the second sample
      if (samples_seen != 0) begin
         diff = (bw >= last_sample) ? 64'(bw - last_sample) : 64'(last_sample - bw);
         difference_sum += diff;
         if (difference_sum > 64'(TS_MAX))
            difference_sum = 64'(TS_MAX);
         quotient = difference_sum / count_after;
         r.step_difference = 32'(diff);
         r.mean_difference = (quotient > 64'(BW_MAX)) ? BW_MAX : 32'(quotient);
         if (last_sample == 0) begin
            // no base to relate to: saturate and flag
            r.step_percent    = BW_MAX;
            r.percent_invalid = 1'b1;
         end else begin
            quotient = (diff * 64'(bss_pkg::PERCENT_SCALE)) / 64'(last_sample);
            r.step_percent = (quotient > 64'(BW_MAX)) ? BW_MAX : 32'(quotient);
         end
      end
      r.difference_total = 48'(difference_sum);

      last_sample  = bw;
      samples_seen = 32'(count_after);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Input side: one transfer, with a random lead-in gap
   // push is left high on return so back-to-back transfers need no bubble
   // ---------------------------------------------------------------------
   task automatic send_sample(input logic [bss_pkg::TS_W-1:0] ts,
                              input logic [bss_pkg::BW_W-1:0] bw);
      int gap;
      gap = send_idle ? $urandom_range(MAX_GAP, 0) : 0;
      repeat (gap) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_timestamp <= ts;
      req_bandwidth <= bw;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      expected_results.push_back(stats_step(ts, bw));
   endtask

   // Stop offering, wait for every outstanding result, then let the block go quiet.
   task automatic drain_results();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write, only ever done with the block idle.
   task automatic write_minimum(input logic [bss_pkg::TS_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ts_minimum = value;
   endtask

   // ---------------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------------
   function automatic logic [bss_pkg::TS_W-1:0] random_timestamp();
      case ($urandom_range(3, 0))
         0: return {16'($urandom), 32'($urandom)};
         // straddle the minimum so relative time goes both ways
         1: return ts_minimum + 48'($urandom_range(1000, 0)) - 48'd500;
         default: begin
            sample_clock_us += 48'($urandom_range(250000, 1));
            return sample_clock_us;
         end
      endcase
   endfunction

   function automatic logic [bss_pkg::BW_W-1:0] random_bandwidth();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return BW_MAX;
         2:       return 32'($urandom_range(3, 0));
         3, 4:    return last_sample + 32'($urandom_range(512, 0)) - 32'd256;
         5, 6:    return $urandom >> $urandom_range(31, 0);
         default: return $urandom;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result side: per-cycle pop driver with random idling and one long hold
   // ---------------------------------------------------------------------
   initial begin : result_receiver
      int wait_left;
      int held;
      wait_left = 0;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop <= 1'b0;
            holding = 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            holding      = 1'b0;
            hold_request = 1'b0;
         end else if (wait_left > 0) begin
            rsp_pop <= 1'b0;
            wait_left--;
            @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
            if (!rsp_empty)
               wait_left = pop_idle ? $urandom_range(MAX_GAP, 0) : 0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker: every accepted transfer against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] expected_value,
                              input logic [63:0] actual_value);
      if (actual_value !== expected_value) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, actual %h",
                     name, expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin : result_checker
      bss_pkg::result_type exp;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result transfer, sample_echo %h", rsp_sample_echo);
         end else begin
            exp = expected_results.pop_front();
            check_field("relative_time",    exp.relative_time,    rsp_relative_time);
            check_field("sample_echo",      exp.sample_echo,      rsp_sample_echo);
            check_field("window_mean",      exp.window_mean,      rsp_window_mean);
            check_field("step_difference",  exp.step_difference,  rsp_step_difference);
            check_field("step_percent",     exp.step_percent,     rsp_step_percent);
            check_field("percent_invalid",  exp.percent_invalid,  rsp_percent_invalid);
            check_field("mean_difference",  exp.mean_difference,  rsp_mean_difference);
            check_field("difference_total", exp.difference_total, rsp_difference_total);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // First item, window warm-up, zero base, exact 100 percent and percent saturation.
   task automatic test_warmup_and_differences();
      send_sample('0,          '0);           // very first transfer: no differences
      send_sample(48'd1,       '0);           // zero base, zero difference
      send_sample(48'd2,       BW_MAX);       // zero base, largest difference
      send_sample(48'd3,       '0);           // full drop: exactly 100 percent
      send_sample(48'd4,       32'd1);        // zero base again, window now full
      send_sample(48'd5,       BW_MAX);       // base of one: percent saturates
      send_sample(48'd6,       32'h100);      // window full, oldest sample drops out
      send_sample(TS_MAX,      32'h100);      // no change
      send_sample(48'd8,       32'h200);      // doubling
      send_sample(48'd9,       32'h8000_0000);
      drain_results();
   endtask

   // Relative time at the extremes of timestamp and minimum, including values below zero.
   task automatic test_relative_time();
      write_minimum(TS_MAX);
      send_sample('0,           $urandom);    // most negative
      send_sample(TS_MAX,       $urandom);    // zero
      send_sample(TS_MAX - 1,   $urandom);    // minus one
      write_minimum('0);
      send_sample(TS_MAX,       $urandom);    // most positive
      write_minimum(48'h8000_0000_0000);
      send_sample('0,           $urandom);
      send_sample(48'h7FFF_FFFF_FFFF, $urandom);
      send_sample(TS_MAX,       $urandom);
      drain_results();
   endtask

   // Receiver stops for a long stretch while samples keep coming: queues fill, full rises.
   task automatic test_back_pressure();
      send_idle    = 1'b0;
      hold_request = 1'b1;
      wait (holding);
      repeat (12)
         send_sample(random_timestamp(), random_bandwidth());
      drain_results();
      send_idle = 1'b1;
   endtask

   // Bulk random traffic under one minimum and one idling pattern.
   task automatic test_random_traffic(input int items,
                                      input logic [bss_pkg::TS_W-1:0] minimum,
                                      input bit idle_in, input bit idle_out);
      write_minimum(minimum);
      send_idle       = idle_in;
      pop_idle        = idle_out;
      sample_clock_us = minimum;
      repeat (items)
         send_sample(random_timestamp(), random_bandwidth());
      drain_results();
      send_idle = 1'b1;
      pop_idle  = 1'b1;
   endtask

   initial begin : test_sequence
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_warmup_and_differences();
      test_relative_time();
      test_back_pressure();
      test_random_traffic(500, {16'($urandom), 32'($urandom)}, 1'b1, 1'b1);
      test_random_traffic(300, '0,                            1'b0, 1'b0);
      test_random_traffic(300, TS_MAX,                        1'b1, 1'b0);
      test_random_traffic(500, {16'($urandom), 32'($urandom)}, 1'b0, 1'b1);

      drain_results();
      if (expected_results.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", expected_results.size());
      end

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
